// ----- rtl/core/srma_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types for the sorted run merge accumulator.
// Used by the top level in rtl/core and by the testbench; depends on nothing.
package srma_pkg;

    localparam int VALUE_W     = 32;
    localparam int RUN_DEPTH   = 256;
    localparam int STORE_DEPTH = 1024;
    localparam int RA_W        = $clog2(RUN_DEPTH);
    localparam int RL_W        = $clog2(RUN_DEPTH + 1);
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int OUT_W       = 48;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_KEY   = 6'b000100,
        S_KWAIT = 6'b001000,
        S_SREAD = 6'b010000,
        S_CMP   = 6'b100000
    } t_state;

endpackage

// ----- rtl/core/srma_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; used for the run buffer and the merged store.
module srma_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sorted_run_merge_accumulator.sv -----
`timescale 1ns / 1ps
// Top level: run collection, insertion merge sequencer and read-out; uses srma_pkg and srma_ram.
// A push, an ignored item or an empty read registers its result in the cycle after acceptance;
// a read with data passes through S_READ first. A close takes each run element through S_KEY,
// S_KWAIT, then S_SREAD and S_CMP per store entry compared (no last S_CMP at the front), as the
// store memory has one read and one write port. One transaction is in flight at a time.
// Synchronous active-low reset empties run and store.
module sorted_run_merge_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // value[31:0]
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // value_out[31:0], is_last[32], status[34:33],
                                     // stored_count[45:35], zero[47:46]
);

    localparam int VW = srma_pkg::VALUE_W;
    localparam int CW = srma_pkg::CNT_W;
    localparam int RW = srma_pkg::RL_W;

    srma_pkg::t_state  r_state, n_state;
    logic [RW-1:0]     r_run_len, n_run_len;
    logic [CW-1:0]     r_mlen, n_mlen;
    logic [CW-1:0]     r_rp, n_rp;
    logic [RW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_j, n_j;
    logic [VW-1:0]     r_key, n_key;
    logic              r_ovalid, n_ovalid;
    logic [VW-1:0]     r_vout, n_vout;
    logic              r_last, n_last;
    srma_pkg::t_status r_stat, n_stat;

    logic                      run_we;
    logic [srma_pkg::RA_W-1:0] run_waddr;
    logic [VW-1:0]             run_rdata;
    logic                      st_we;
    logic [srma_pkg::SA_W-1:0] st_waddr, st_raddr;
    logic [VW-1:0]             st_wdata, st_rdata;
    logic                      s_acc;
    logic                      full;
    logic [CW-1:0]             j_m1;
    srma_pkg::t_mode           mode;

    assign mode  = srma_pkg::t_mode'(i_s_tuser);
    assign s_acc = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == srma_pkg::S_IDLE) && !r_ovalid;
    assign full = (r_run_len == RW'(srma_pkg::RUN_DEPTH)) ||
                  (({1'b0, r_mlen} + (CW+1)'(r_run_len) + (CW+1)'(1))
                   > (CW+1)'(srma_pkg::STORE_DEPTH));
    assign j_m1 = r_j - CW'(1);
    assign run_waddr = r_run_len[srma_pkg::RA_W-1:0];
    assign st_raddr  = (r_state == srma_pkg::S_IDLE) ? r_rp[srma_pkg::SA_W-1:0]
                                                     : j_m1[srma_pkg::SA_W-1:0];

    srma_ram #(.DEPTH(srma_pkg::RUN_DEPTH), .WIDTH(VW)) u_run (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (run_waddr),
        .i_wdata (i_s_tdata),
        .i_raddr (r_k[srma_pkg::RA_W-1:0]),
        .o_rdata (run_rdata)
    );

    srma_ram #(.DEPTH(srma_pkg::STORE_DEPTH), .WIDTH(VW)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_run_len = r_run_len;
        n_mlen    = r_mlen;
        n_rp      = r_rp;
        n_k       = r_k;
        n_j       = r_j;
        n_key     = r_key;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_vout    = r_vout;
        n_last    = r_last;
        n_stat    = r_stat;
        run_we    = 1'b0;
        st_we     = 1'b0;
        st_waddr  = r_j[srma_pkg::SA_W-1:0];
        st_wdata  = r_key;
        case (r_state)
            srma_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_vout = '0;
                    n_last = 1'b0;
                    n_stat = srma_pkg::ST_OK;
                    case (mode)
                        srma_pkg::MODE_PUSH: begin
                            n_ovalid = 1'b1;
                            if (full) begin
                                n_stat = srma_pkg::ST_FULL;
                            end else begin
                                run_we    = 1'b1;
                                n_run_len = r_run_len + RW'(1);
                            end
                        end
                        srma_pkg::MODE_CLOSE: begin
                            n_k     = '0;
                            n_state = srma_pkg::S_KEY;
                        end
                        srma_pkg::MODE_READ: begin
                            if (r_rp >= r_mlen) begin
                                n_stat   = srma_pkg::ST_EMPTY;
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = srma_pkg::S_READ;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            srma_pkg::S_READ: begin
                n_vout   = st_rdata;
                n_last   = (r_rp + CW'(1)) == r_mlen;
                n_rp     = r_rp + CW'(1);
                n_ovalid = 1'b1;
                n_state  = srma_pkg::S_IDLE;
            end
            srma_pkg::S_KEY: begin
                if (r_k == r_run_len) begin
                    n_run_len = '0;
                    n_rp      = '0;
                    n_ovalid  = 1'b1;
                    n_state   = srma_pkg::S_IDLE;
                end else begin
                    n_state = srma_pkg::S_KWAIT;
                end
            end
            srma_pkg::S_KWAIT: begin
                n_key   = run_rdata;
                n_j     = r_mlen;
                n_state = srma_pkg::S_SREAD;
            end
            srma_pkg::S_SREAD: begin
                if (r_j == '0) begin
                    st_we   = 1'b1;
                    n_mlen  = r_mlen + CW'(1);
                    n_k     = r_k + RW'(1);
                    n_state = srma_pkg::S_KEY;
                end else begin
                    n_state = srma_pkg::S_CMP;
                end
            end
            srma_pkg::S_CMP: begin
                st_we = 1'b1;
                if ($signed(r_key) < $signed(st_rdata)) begin
                    st_wdata = st_rdata;
                    n_j      = j_m1;
                    n_state  = srma_pkg::S_SREAD;
                end else begin
                    n_mlen  = r_mlen + CW'(1);
                    n_k     = r_k + RW'(1);
                    n_state = srma_pkg::S_KEY;
                end
            end
            default: begin
                n_state = srma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srma_pkg::S_IDLE;
            r_run_len <= '0;
            r_mlen    <= '0;
            r_rp      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_run_len <= n_run_len;
            r_mlen    <= n_mlen;
            r_rp      <= n_rp;
            r_ovalid  <= n_ovalid;
        end
        r_k    <= n_k;
        r_j    <= n_j;
        r_key  <= n_key;
        r_vout <= n_vout;
        r_last <= n_last;
        r_stat <= n_stat;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_mlen, r_stat, r_last, r_vout};

`ifndef SYNTHESIS
    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_mlen) else $error("read pointer beyond store length");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srma_pkg::S_IDLE) |->
        (({1'b0, r_mlen} + (CW+1)'(r_run_len)) <= (CW+1)'(srma_pkg::STORE_DEPTH)))
        else $error("run plus store exceed capacity");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_ovalid || r_state != srma_pkg::S_IDLE))
        else $error("accepted item produced no work");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_run_merge_accumulator: directed rows with expected
// results, then random runs of pushes, closes and reads checked by a sorted-store model.
// Depends on srma_pkg and the RTL top level.
module testbench;

    localparam int WDOG_LIMIT = 5000000;

    typedef struct {
        logic [31:0]       val;
        logic              last;
        srma_pkg::t_status st;
        logic [10:0]       cnt;
    } t_result;

    typedef struct {
        srma_pkg::t_mode mode;
        logic [31:0]     val;
        bit              typed;
        t_result         res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold = 0;
    int          fails = 0;
    int          quiet_cycles = 0;
    int          n_items = 0, n_closes = 0, n_reads = 0, n_dropped = 0, n_dry = 0;

    int          sorted_store[$];
    int          open_run[$];
    int          rd_pos = 0;
    t_result     pending_q[$];
    t_row        dir_table[$];

    always #6 i_clk = ~i_clk;

    sorted_run_merge_accumulator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    function automatic t_result blank_result();
        t_result r;
        r.val  = '0;
        r.last = 1'b0;
        r.st   = srma_pkg::ST_OK;
        r.cnt  = '0;
        return r;
    endfunction

    function automatic t_result apply_item(srma_pkg::t_mode mode, logic [31:0] val);
        t_result r;
        int      pos;
        r.val  = '0;
        r.last = 1'b0;
        r.st   = srma_pkg::ST_OK;
        case (mode)
            srma_pkg::MODE_PUSH: begin
                if (open_run.size() >= srma_pkg::RUN_DEPTH ||
                    sorted_store.size() + open_run.size() + 1 > srma_pkg::STORE_DEPTH) begin
                    r.st = srma_pkg::ST_FULL;
                end else begin
                    open_run.push_back($signed(val));
                end
            end
            srma_pkg::MODE_CLOSE: begin
                foreach (open_run[k]) begin
                    pos = 0;
                    while (pos < sorted_store.size() && sorted_store[pos] < open_run[k])
                        pos++;
                    sorted_store.insert(pos, open_run[k]);
                end
                open_run.delete();
                rd_pos = 0;
            end
            srma_pkg::MODE_READ: begin
                if (rd_pos >= sorted_store.size()) begin
                    r.st = srma_pkg::ST_EMPTY;
                end else begin
                    r.val  = sorted_store[rd_pos];
                    r.last = (rd_pos + 1 == sorted_store.size());
                    rd_pos++;
                end
            end
            default: ;
        endcase
        r.cnt = 11'(sorted_store.size());
        return r;
    endfunction

    task automatic send_item(srma_pkg::t_mode mode, logic [31:0] val, bit typed,
                             t_result typed_res);
        t_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = val;
        do @(posedge i_clk); while (!s_tready);
        r = apply_item(mode, val);
        pending_q.push_back(typed ? typed_res : r);
        n_items++;
        if (mode == srma_pkg::MODE_CLOSE) n_closes++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic add_row(srma_pkg::t_mode mode, logic [31:0] val, bit typed,
                           srma_pkg::t_status st, int cnt);
        t_row row;
        row.mode     = mode;
        row.val      = val;
        row.typed    = typed;
        row.res.val  = '0;
        row.res.last = 1'b0;
        row.res.st   = st;
        row.res.cnt  = 11'(cnt);
        dir_table.push_back(row);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(19))
            0, 1:    return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            2, 3, 4: return 32'($signed($urandom_range(6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_runs(int n_target);
        int      start;
        int      len;
        int      n_rd;
        t_result none;
        none  = blank_result();
        start = n_items;
        while (n_items - start < n_target) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            repeat (len) send_item(srma_pkg::MODE_PUSH, pick_value(), 0, none);
            if ($urandom_range(19) == 0) send_item(srma_pkg::MODE_NONE, $urandom, 0, none);
            if ($urandom_range(19) != 0) send_item(srma_pkg::MODE_CLOSE, $urandom, 0, none);
            if (sorted_store.size() <= 60 && $urandom_range(3) == 0)
                n_rd = sorted_store.size() + 1;
            else
                n_rd = $urandom_range(6);
            repeat (n_rd) send_item(srma_pkg::MODE_READ, $urandom, 0, none);
        end
        wait (pending_q.size() == 0);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold  = rx_hold - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                fails++;
            end else begin
                exp_r = pending_q.pop_front();
                if (m_tdata[31:0] !== exp_r.val || m_tdata[32] !== exp_r.last ||
                    m_tdata[34:33] !== exp_r.st || m_tdata[45:35] !== exp_r.cnt ||
                    m_tdata[47:46] !== 2'b00) begin
                    $display("%0t: mismatch expected val=%h last=%b st=%0d cnt=%0d, got %h",
                             $time, exp_r.val, exp_r.last, exp_r.st, exp_r.cnt, m_tdata);
                    $display("%0t:   actual val=%h last=%b st=%0d cnt=%0d", $time,
                             m_tdata[31:0], m_tdata[32], m_tdata[34:33], m_tdata[45:35]);
                    fails++;
                end
                if (m_tdata[34:33] == srma_pkg::ST_FULL) n_dropped++;
                if (m_tdata[34:33] == srma_pkg::ST_EMPTY) n_dry++;
                if (exp_r.st == srma_pkg::ST_OK && m_tdata[32]) n_reads++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results pending", $time,
                         pending_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_result none;
        none = blank_result();
        add_row(srma_pkg::MODE_READ,  32'h0,        1, srma_pkg::ST_EMPTY, 0);
        add_row(srma_pkg::MODE_NONE,  32'hffffffff, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_CLOSE, 32'h0,        1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_PUSH,  32'h7fffffff, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_PUSH,  32'h80000000, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_PUSH,  32'h00000000, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_PUSH,  32'hffffffff, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_PUSH,  32'h00000001, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_PUSH,  32'h00000000, 1, srma_pkg::ST_OK,    0);
        add_row(srma_pkg::MODE_CLOSE, 32'h0,        1, srma_pkg::ST_OK,    6);
        repeat (6) add_row(srma_pkg::MODE_READ, 32'h0, 0, srma_pkg::ST_OK, 0);
        add_row(srma_pkg::MODE_READ,  32'h0,        1, srma_pkg::ST_EMPTY, 6);
        add_row(srma_pkg::MODE_PUSH,  32'hffffffff, 1, srma_pkg::ST_OK,    6);
        add_row(srma_pkg::MODE_PUSH,  32'h00000005, 1, srma_pkg::ST_OK,    6);
        add_row(srma_pkg::MODE_CLOSE, 32'h0,        1, srma_pkg::ST_OK,    8);
        repeat (3) add_row(srma_pkg::MODE_READ, 32'h0, 0, srma_pkg::ST_OK, 0);
        add_row(srma_pkg::MODE_NONE,  32'h0,        1, srma_pkg::ST_OK,    8);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[k])
            send_item(dir_table[k].mode, dir_table[k].val, dir_table[k].typed,
                      dir_table[k].res);
        wait (pending_q.size() == 0);

        tx_idle_pct = 22;
        rx_idle_pct = 82;
        // One oversized run fills the run buffer so the last pushes are dropped.
        repeat (260) send_item(srma_pkg::MODE_PUSH, pick_value(), 0, none);
        send_item(srma_pkg::MODE_CLOSE, 32'h0, 0, none);
        rx_hold = 300;
        repeat (12) send_item(srma_pkg::MODE_PUSH, pick_value(), 0, none);
        random_runs(230);

        tx_idle_pct = 82;
        rx_idle_pct = 22;
        random_runs(500);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_runs(500);

        repeat (50) @(posedge i_clk);
        $display("Sent %0d items with %0d closes; store holds %0d values.", n_items,
                 n_closes, sorted_store.size());
        $display("Saw %0d final-element reads, %0d dropped pushes, %0d empty reads.",
                 n_reads, n_dropped, n_dry);
        if (fails == 0 && pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
